// File: rtl/core/bresenham_line_stepper_defines.svh
// assertion macros for the bresenham line stepper checker
// no dependencies; included by the checker file
`ifndef BRESENHAM_LINE_STEPPER_DEFINES_SVH
`define BRESENHAM_LINE_STEPPER_DEFINES_SVH

// same-cycle implication, masked while reset is low
`define BLSP_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("blsp check failed");

// next-cycle implication, also checked through reset
`define BLSP_ASSERT_NEXT(label, clk, a, b) \
    label: assert property (@(posedge clk) (a) |=> (b)) \
        else $error("blsp check failed");

`endif

// File: rtl/core/blsp_pkg.sv
// shared types and constants of the bresenham line stepper
// no dependencies
package blsp_pkg;

    localparam int COORD_BITS = 12;
    localparam int COLOR_BITS = 24;
    localparam int ERR_BITS   = COORD_BITS + 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef enum logic [1:0] {
        OCT_SHALLOW_RISE = 2'd0,
        OCT_STEEP_RISE   = 2'd1,
        OCT_SHALLOW_FALL = 2'd2,
        OCT_STEEP_FALL   = 2'd3
    } t_octant;

    typedef struct packed {
        logic                  cmd;
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] end_y;
        logic [COLOR_BITS-1:0] line_color;
    } t_cmd_in;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  pixel_valid;
        logic                  last_pixel;
    } t_pix_out;

    // classified item handed from front to back
    typedef struct packed {
        logic                  is_step;
        logic [COORD_BITS-1:0] lo_x;
        logic [COORD_BITS-1:0] lo_y;
        logic [COORD_BITS-1:0] span_x;
        logic [COORD_BITS-1:0] span_y;
        logic                  rising;
        logic [COLOR_BITS-1:0] color;
    } t_entry;

endpackage

// File: rtl/core/blsp_front.sv
// front end: accepts items, orders endpoints and measures spans
// depends on blsp_pkg
module blsp_front import blsp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    output logic    o_cmd_ready,
    input  t_cmd_in i_cmd,
    output logic    o_ent_valid,
    input  logic    i_ent_ready,
    output t_entry  o_ent
);

    logic   r_valid;
    t_entry r_ent;
    t_entry n_ent;
    logic   w_swap;
    logic [COORD_BITS-1:0] w_lx, w_ly, w_hx, w_hy;

    assign w_swap = i_cmd.start_x > i_cmd.end_x;
    assign w_lx   = w_swap ? i_cmd.end_x   : i_cmd.start_x;
    assign w_ly   = w_swap ? i_cmd.end_y   : i_cmd.start_y;
    assign w_hx   = w_swap ? i_cmd.start_x : i_cmd.end_x;
    assign w_hy   = w_swap ? i_cmd.start_y : i_cmd.end_y;

    always_comb begin
        n_ent.is_step = (i_cmd.cmd == CMD_STEP);
        n_ent.lo_x    = w_lx;
        n_ent.lo_y    = w_ly;
        n_ent.span_x  = w_hx - w_lx;
        n_ent.rising  = w_ly < w_hy;
        n_ent.span_y  = n_ent.rising ? (w_hy - w_ly) : (w_ly - w_hy);
        n_ent.color   = i_cmd.line_color;
    end

    assign o_cmd_ready = !r_valid || i_ent_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_cmd_ready) begin
            r_valid <= i_cmd_valid;
        end
        if (o_cmd_ready && i_cmd_valid) begin
            r_ent <= n_ent;
        end
    end

    assign o_ent_valid = r_valid;
    assign o_ent       = r_ent;

endmodule

// File: rtl/core/blsp_queue.sv
// two-entry queue between front and back end
// depends on blsp_pkg
module blsp_queue import blsp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push_valid,
    output logic   o_push_ready,
    input  t_entry i_push,
    output logic   o_pop_valid,
    input  logic   i_pop_ready,
    output t_entry o_pop
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    t_entry r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wp, r_rp;
    logic [PTR_BITS:0]   r_cnt;
    logic w_push, w_pop;

    assign o_push_ready = r_cnt != (PTR_BITS+1)'(QUEUE_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign w_push = i_push_valid && o_push_ready;
    assign w_pop  = o_pop_valid && i_pop_ready;
    assign o_pop  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (w_push) begin
            r_mem[r_wp] <= i_push;
        end
    end

endmodule

// File: rtl/core/blsp_back.sv
// back end: line state, error stepping and output register
// depends on blsp_pkg
module blsp_back import blsp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_ent_valid,
    output logic     o_ent_ready,
    input  t_entry   i_ent,
    output logic     o_pix_valid,
    input  logic     i_pix_ready,
    output t_pix_out o_pix
);

    logic [COORD_BITS-1:0] r_major_pos, r_minor_pos, r_major_delta, r_minor_delta;
    logic [COORD_BITS-1:0] r_anchor, r_steps_left;
    logic signed [ERR_BITS-1:0] r_err;
    t_octant r_mode;
    logic [COLOR_BITS-1:0] r_color;
    logic     r_out_valid;
    t_pix_out r_out;

    logic w_out_free, w_pop, w_start, w_step, w_shallow, w_active;
    logic [COORD_BITS-1:0] w_maj_new, w_min_new, w_mir_src, w_mirror;
    logic signed [ERR_BITS-1:0] w_min2_new, w_maj_new_ext, w_min2, w_maj2;
    t_pix_out n_out;

    assign w_out_free  = !r_out_valid || i_pix_ready;
    assign o_ent_ready = !i_ent.is_step || w_out_free;
    assign w_pop   = i_ent_valid && o_ent_ready;
    assign w_start = w_pop && !i_ent.is_step;
    assign w_step  = w_pop && i_ent.is_step;
    assign w_active = r_steps_left != '0;

    // start setup
    assign w_shallow = i_ent.span_x > i_ent.span_y;
    assign w_maj_new = w_shallow ? i_ent.span_x : i_ent.span_y;
    assign w_min_new = w_shallow ? i_ent.span_y : i_ent.span_x;
    assign w_min2_new    = {{(ERR_BITS-COORD_BITS-1){1'b0}}, w_min_new, 1'b0};
    assign w_maj_new_ext = {{(ERR_BITS-COORD_BITS){1'b0}}, w_maj_new};

    assign w_min2 = {{(ERR_BITS-COORD_BITS-1){1'b0}}, r_minor_delta, 1'b0};
    assign w_maj2 = {{(ERR_BITS-COORD_BITS-1){1'b0}}, r_major_delta, 1'b0};

    // falling lines reflect about the start y, wrapping at the grid size
    assign w_mir_src = (r_mode == OCT_STEEP_FALL) ? r_major_pos : r_minor_pos;
    assign w_mirror  = {r_anchor[COORD_BITS-2:0], 1'b0} - w_mir_src;

    always_comb begin
        n_out = '0;
        if (w_active) begin
            case (r_mode)
                OCT_SHALLOW_RISE: begin
                    n_out.pixel_x = r_major_pos;
                    n_out.pixel_y = r_minor_pos;
                end
                OCT_STEEP_RISE: begin
                    n_out.pixel_x = r_minor_pos;
                    n_out.pixel_y = r_major_pos;
                end
                OCT_SHALLOW_FALL: begin
                    n_out.pixel_x = r_major_pos;
                    n_out.pixel_y = w_mirror;
                end
                default: begin
                    n_out.pixel_x = r_minor_pos;
                    n_out.pixel_y = w_mirror;
                end
            endcase
            n_out.pixel_color = r_color;
            n_out.pixel_valid = 1'b1;
            n_out.last_pixel  = r_steps_left == COORD_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps_left <= '0;
            r_mode       <= OCT_SHALLOW_RISE;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_out_free) begin
                r_out_valid <= w_step;
            end
            if (w_start) begin
                r_mode       <= t_octant'({!i_ent.rising, !w_shallow});
                r_steps_left <= w_maj_new;
            end else if (w_step && w_active) begin
                r_steps_left <= r_steps_left - 1'b1;
            end
        end
        if (w_start) begin
            r_major_pos   <= w_shallow ? i_ent.lo_x : i_ent.lo_y;
            r_minor_pos   <= w_shallow ? i_ent.lo_y : i_ent.lo_x;
            r_major_delta <= w_maj_new;
            r_minor_delta <= w_min_new;
            r_anchor      <= i_ent.lo_y;
            r_err         <= w_min2_new - w_maj_new_ext;
            r_color       <= i_ent.color;
        end else if (w_step && w_active) begin
            r_major_pos <= r_major_pos + 1'b1;
            if (r_err >= 0) begin
                r_minor_pos <= r_minor_pos + 1'b1;
                r_err       <= r_err + w_min2 - w_maj2;
            end else begin
                r_err <= r_err + w_min2;
            end
        end
        if (w_out_free && w_step) begin
            r_out <= n_out;
        end
    end

    assign o_pix_valid = r_out_valid;
    assign o_pix       = r_out;

endmodule

// File: rtl/core/bresenham_line_stepper.sv
// path: a step beat's pixel passes the front register, the queue and the
// output register in that order; a start beat gives no result
// throughput: one beat per cycle while the pixel output is not stalled, set by the error update loop
// reset: synchronous, active low; clears handshakes, queue and the line count
// so that a step beat after reset returns an empty pixel
module bresenham_line_stepper import blsp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cmd_valid,
    output logic     o_cmd_ready,
    input  t_cmd_in  i_cmd,
    output logic     o_pix_valid,
    input  logic     i_pix_ready,
    output t_pix_out o_pix
);

    t_entry w_front_ent, w_queue_ent;
    logic   w_front_valid, w_front_ready, w_queue_valid, w_back_ready;

    blsp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd_valid),
        .o_cmd_ready (o_cmd_ready),
        .i_cmd       (i_cmd),
        .o_ent_valid (w_front_valid),
        .i_ent_ready (w_front_ready),
        .o_ent       (w_front_ent)
    );

    blsp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_front_valid),
        .o_push_ready (w_front_ready),
        .i_push       (w_front_ent),
        .o_pop_valid  (w_queue_valid),
        .i_pop_ready  (w_back_ready),
        .o_pop        (w_queue_ent)
    );

    blsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ent_valid (w_queue_valid),
        .o_ent_ready (w_back_ready),
        .i_ent       (w_queue_ent),
        .o_pix_valid (o_pix_valid),
        .i_pix_ready (i_pix_ready),
        .o_pix       (o_pix)
    );

endmodule

// File: rtl/core/blsp_checker.sv
// port-level checker for the bresenham line stepper, bound to the top level
// depends on blsp_pkg and bresenham_line_stepper_defines.svh
`include "bresenham_line_stepper_defines.svh"

module blsp_checker import blsp_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_cmd_ready,
    input logic     o_pix_valid,
    input logic     i_pix_ready,
    input t_pix_out o_pix
);

    // no beat leaves or is refused straight after reset
    `BLSP_ASSERT_NEXT(a_out_idle_after_reset, i_clk, !i_rst_n, !o_pix_valid)
    `BLSP_ASSERT_NEXT(a_ready_after_reset, i_clk, !i_rst_n, o_cmd_ready)

    // an empty pixel carries no last flag and zero coordinates
    `BLSP_ASSERT_IMPLY(a_empty_pixel_clean, i_clk, i_rst_n,
        o_pix_valid && !o_pix.pixel_valid,
        !o_pix.last_pixel && o_pix.pixel_x == '0 && o_pix.pixel_y == '0)

    // a stalled result beat holds
    `BLSP_ASSERT_NEXT(a_out_hold, i_clk,
        i_rst_n && o_pix_valid && !i_pix_ready,
        !i_rst_n || (o_pix_valid && $stable(o_pix)))

endmodule

bind bresenham_line_stepper blsp_checker u_blsp_checker (.*);
